### rtl/triangle_area_heron_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Heron triangle area block.
// Short forms for clocked assertions with reset disable.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_AREA_HERON_ASSERT_SVH
`define TRIANGLE_AREA_HERON_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tah_pkg.sv
// ---------------------------------------------------------------------------
// tah_pkg
// Widths and stage counts shared by the Heron triangle area pipeline.
// ---------------------------------------------------------------------------
package tah_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int SIDE_BITS  = 24;
  localparam int AREA_BITS  = 40;

  // Squared distance and its fixed-point radicand, padded to an even width.
  localparam int SQ_BITS  = 2 * COORD_BITS + 1;
  localparam int DN_RAW   = SQ_BITS + 2 * FRAC_BITS;
  localparam int DN_BITS  = DN_RAW + (DN_RAW % 2);
  localparam int DSTEPS   = DN_BITS / 2;
  localparam int DRW      = DSTEPS + 2;
  localparam int DLAT     = 3 + DSTEPS;

  localparam int LEN_BITS = (DSTEPS > SIDE_BITS) ? DSTEPS : SIDE_BITS;
  localparam int FAC_BITS = LEN_BITS + 2;
  localparam int PROD_BITS = 4 * FAC_BITS;
  localparam int ASTEPS   = 2 * FAC_BITS;
  localparam int ARW      = ASTEPS + 2;
  localparam int SHIFT    = FRAC_BITS + 2;
  localparam int Q_BITS   = ASTEPS - SHIFT;

endpackage

### rtl/tah_dist.sv
// ---------------------------------------------------------------------------
// tah_dist
// Pipelined side length from two vertices: truncated fixed-point square root
// of the squared distance, one root bit per stage.
// ---------------------------------------------------------------------------
module tah_dist (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [tah_pkg::COORD_BITS-1:0] x1_i,
  input  logic signed [tah_pkg::COORD_BITS-1:0] y1_i,
  input  logic signed [tah_pkg::COORD_BITS-1:0] x2_i,
  input  logic signed [tah_pkg::COORD_BITS-1:0] y2_i,
  output logic        [tah_pkg::DSTEPS-1:0]     len_o
);

  localparam int CB = tah_pkg::COORD_BITS;
  localparam int DN = tah_pkg::DN_BITS;
  localparam int DS = tah_pkg::DSTEPS;
  localparam int RW = tah_pkg::DRW;

  logic signed [CB:0]         dx, dy;
  logic        [CB:0]         ax, ay;
  logic        [CB-1:0]       ux_q, uy_q;
  logic        [2*CB-1:0]     sx_q, sy_q;
  logic        [tah_pkg::SQ_BITS-1:0] sum;
  logic        [DN-1:0]       n_q    [0:DS];
  logic        [RW-1:0]       rem_q  [0:DS];
  logic        [DS-1:0]       root_q [0:DS];
  logic        [RW-1:0]       rem2   [0:DS-1];
  logic        [RW-1:0]       trial  [0:DS-1];
  logic        [RW-1:0]       rem_d  [0:DS-1];
  logic        [DS-1:0]       root_d [0:DS-1];

  assign dx  = {x1_i[CB-1], x1_i} - {x2_i[CB-1], x2_i};
  assign dy  = {y1_i[CB-1], y1_i} - {y2_i[CB-1], y2_i};
  assign ax  = dx[CB] ? (CB+1)'(-dx) : dx;
  assign ay  = dy[CB] ? (CB+1)'(-dy) : dy;
  assign sum = {1'b0, sx_q} + {1'b0, sy_q};

  always_comb begin
    for (int k = 0; k < DS; k++) begin
      rem2[k]  = {rem_q[k][RW-3:0], n_q[k][DN-1 -: 2]};
      trial[k] = {root_q[k], 2'b01};
      if (rem2[k] >= trial[k]) begin
        rem_d[k]  = rem2[k] - trial[k];
        root_d[k] = {root_q[k][DS-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem2[k];
        root_d[k] = {root_q[k][DS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q      <= ax[CB-1:0];
      uy_q      <= ay[CB-1:0];
      sx_q      <= ux_q * ux_q;
      sy_q      <= uy_q * uy_q;
      n_q[0]    <= DN'(sum) << (2 * tah_pkg::FRAC_BITS);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      for (int k = 0; k < DS; k++) begin
        n_q[k+1]    <= n_q[k] << 2;
        rem_q[k+1]  <= rem_d[k];
        root_q[k+1] <= root_d[k];
      end
    end
  end

  assign len_o = root_q[DS];

endmodule

### rtl/triangle_area_heron.sv
// ---------------------------------------------------------------------------
// triangle_area_heron
// Triangle existence check and Heron area from sides or integer vertices.
// ---------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser selects side mode (0) or vertex
// mode (1), tdata carries the three signed Q15.8 sides and six coordinates.
// Results leave on the m_axis channel: tuser is the exists flag, tdata the
// Q32.8 area, zero for an invalid triangle and saturated at its maximum.
// The datapath is one pipeline of 88 register stages: a result is shown on
// m_axis from the output register once its request has passed through every
// stage. One item is accepted per cycle while the output is not stalled.
// The stage count is set by the two pipelined square roots: 28 stages for the
// vertex distances (25 of them root bits) and 55 stages for the Heron root
// (54 of them root bits), plus four stages for the factors and products
// and the output register.
// The whole pipeline advances together: when the output register holds a
// result that the receiver does not take, every stage holds and s_axis_tready
// is low; nothing is dropped or repeated.
// Reset clears all valid bits; no result is pending after reset.
// ---------------------------------------------------------------------------
module triangle_area_heron (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // side_a, side_b, side_c, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
  // vert_c_x, vert_c_y
  input  logic [167:0] s_axis_tdata,
  // req_type
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // area
  output logic [39:0]  m_axis_tdata,
  // exists
  output logic [0:0]   m_axis_tuser
);

  localparam int SB  = tah_pkg::SIDE_BITS;
  localparam int LB  = tah_pkg::LEN_BITS;
  localparam int FB  = tah_pkg::FAC_BITS;
  localparam int PB  = tah_pkg::PROD_BITS;
  localparam int AS  = tah_pkg::ASTEPS;
  localparam int RW  = tah_pkg::ARW;
  localparam int DL  = tah_pkg::DLAT;
  localparam int QB  = tah_pkg::Q_BITS;
  localparam int AB  = tah_pkg::AREA_BITS;

  logic en;
  logic signed [SB-1:0] side_a, side_b, side_c;
  logic [SB-1:0] mag_a, mag_b, mag_c;
  logic [tah_pkg::DSTEPS-1:0] len_a, len_b, len_c;

  logic          dv_q [1:DL];
  logic          dt_q [1:DL];
  logic [SB-1:0] da_q [1:DL];
  logic [SB-1:0] db_q [1:DL];
  logic [SB-1:0] dc_q [1:DL];

  logic [LB-1:0] a_q, b_q, c_q;
  logic          v1_q, v2_q, v3_q, v4_q;
  logic          ok2_q, ok3_q, ok4_q;
  logic [LB:0]   sab, sbc, sac;
  logic [FB-1:0] f1_q, f2_q, f3_q, f4_q;
  logic [2*FB-1:0] p12_q, p34_q;
  logic [2*FB-1:0] hh_q, hl_q, lh_q, ll_q;
  logic [2*FB:0]   mid;

  logic          av_q   [0:AS];
  logic          aok_q  [0:AS];
  logic [PB-1:0] an_q   [0:AS];
  logic [RW-1:0] arem_q [0:AS];
  logic [AS-1:0] aroot_q [0:AS];
  logic [RW-1:0] arem2  [0:AS-1];
  logic [RW-1:0] atrial [0:AS-1];
  logic [RW-1:0] arem_d [0:AS-1];
  logic [AS-1:0] aroot_d [0:AS-1];

  logic [QB-1:0] q;
  logic          ov_q;
  logic          exists_q;
  logic [AB-1:0] area_q;

  assign en            = !ov_q || m_axis_tready;
  assign s_axis_tready = en;

  assign side_a = s_axis_tdata[23:0];
  assign side_b = s_axis_tdata[47:24];
  assign side_c = s_axis_tdata[71:48];
  assign mag_a  = side_a[SB-1] ? SB'(-side_a) : side_a;
  assign mag_b  = side_b[SB-1] ? SB'(-side_b) : side_b;
  assign mag_c  = side_c[SB-1] ? SB'(-side_c) : side_c;

  // Side c joins A and B, side a joins B and C, side b joins A and C.
  tah_dist u_dist_c (
    .clk_i (clk_i), .en_i (en),
    .x1_i  (s_axis_tdata[87:72]),   .y1_i (s_axis_tdata[103:88]),
    .x2_i  (s_axis_tdata[119:104]), .y2_i (s_axis_tdata[135:120]),
    .len_o (len_c)
  );

  tah_dist u_dist_a (
    .clk_i (clk_i), .en_i (en),
    .x1_i  (s_axis_tdata[119:104]), .y1_i (s_axis_tdata[135:120]),
    .x2_i  (s_axis_tdata[151:136]), .y2_i (s_axis_tdata[167:152]),
    .len_o (len_a)
  );

  tah_dist u_dist_b (
    .clk_i (clk_i), .en_i (en),
    .x1_i  (s_axis_tdata[87:72]),   .y1_i (s_axis_tdata[103:88]),
    .x2_i  (s_axis_tdata[151:136]), .y2_i (s_axis_tdata[167:152]),
    .len_o (len_b)
  );

  assign sab = {1'b0, a_q} + {1'b0, b_q};
  assign sbc = {1'b0, b_q} + {1'b0, c_q};
  assign sac = {1'b0, a_q} + {1'b0, c_q};
  assign mid = {1'b0, hl_q} + {1'b0, lh_q};

  always_comb begin
    for (int k = 0; k < AS; k++) begin
      arem2[k]  = {arem_q[k][RW-3:0], an_q[k][PB-1 -: 2]};
      atrial[k] = {aroot_q[k], 2'b01};
      if (arem2[k] >= atrial[k]) begin
        arem_d[k]  = arem2[k] - atrial[k];
        aroot_d[k] = {aroot_q[k][AS-2:0], 1'b1};
      end else begin
        arem_d[k]  = arem2[k];
        aroot_d[k] = {aroot_q[k][AS-2:0], 1'b0};
      end
    end
  end

  assign q = aroot_q[AS][AS-1:tah_pkg::SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= DL; k++) begin
        dv_q[k] <= 1'b0;
      end
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int k = 0; k <= AS; k++) begin
        av_q[k] <= 1'b0;
      end
      ov_q <= 1'b0;
    end else if (en) begin
      dv_q[1] <= s_axis_tvalid;
      for (int k = 1; k < DL; k++) begin
        dv_q[k+1] <= dv_q[k];
      end
      v1_q    <= dv_q[DL];
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      av_q[0] <= v4_q;
      for (int k = 0; k < AS; k++) begin
        av_q[k+1] <= av_q[k];
      end
      ov_q <= av_q[AS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dt_q[1] <= s_axis_tuser[0];
      da_q[1] <= mag_a;
      db_q[1] <= mag_b;
      dc_q[1] <= mag_c;
      for (int k = 1; k < DL; k++) begin
        dt_q[k+1] <= dt_q[k];
        da_q[k+1] <= da_q[k];
        db_q[k+1] <= db_q[k];
        dc_q[k+1] <= dc_q[k];
      end

      if (dt_q[DL]) begin
        a_q <= LB'(len_a);
        b_q <= LB'(len_b);
        c_q <= LB'(len_c);
      end else begin
        a_q <= LB'(da_q[DL]);
        b_q <= LB'(db_q[DL]);
        c_q <= LB'(dc_q[DL]);
      end

      ok2_q <= (sab >= {1'b0, c_q}) && (sbc >= {1'b0, a_q}) && (sac >= {1'b0, b_q});
      f1_q  <= FB'(sab) + FB'(c_q);
      f2_q  <= FB'(sbc) - FB'(a_q);
      f3_q  <= FB'(sac) - FB'(b_q);
      f4_q  <= FB'(sab) - FB'(c_q);

      ok3_q <= ok2_q;
      p12_q <= f1_q * f2_q;
      p34_q <= f3_q * f4_q;

      ok4_q <= ok3_q;
      hh_q  <= p12_q[2*FB-1:FB] * p34_q[2*FB-1:FB];
      hl_q  <= p12_q[2*FB-1:FB] * p34_q[FB-1:0];
      lh_q  <= p12_q[FB-1:0]    * p34_q[2*FB-1:FB];
      ll_q  <= p12_q[FB-1:0]    * p34_q[FB-1:0];

      aok_q[0]   <= ok4_q;
      an_q[0]    <= {hh_q, ll_q} + (PB'(mid) << FB);
      arem_q[0]  <= '0;
      aroot_q[0] <= '0;
      for (int k = 0; k < AS; k++) begin
        aok_q[k+1]   <= aok_q[k];
        an_q[k+1]    <= an_q[k] << 2;
        arem_q[k+1]  <= arem_d[k];
        aroot_q[k+1] <= aroot_d[k];
      end

      exists_q <= aok_q[AS];
      if (!aok_q[AS]) begin
        area_q <= '0;
      end else if (|q[QB-1:AB]) begin
        area_q <= '1;
      end else begin
        area_q <= q[AB-1:0];
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = area_q;
  assign m_axis_tuser  = exists_q;

endmodule

### rtl/tah_checker.sv
// ---------------------------------------------------------------------------
// tah_checker
// Port-level checks of the Heron triangle area block, bound to the top level.
// ---------------------------------------------------------------------------
`include "triangle_area_heron_assert.svh"

module tah_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  `TAH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled item changed")
  `TAH_ASSERT_SAME(a_zero_area, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 40'd0, "invalid triangle with nonzero area")
  `TAH_ASSERT_SAME(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
  `TAH_ASSERT_SAME(a_ready_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

endmodule

bind triangle_area_heron tah_checker u_tah_checker (.*);

### verif/triangle_area_heron_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// triangle_area_heron_tb
// Checks existence flag and Heron area for side and vertex requests against
// an exact integer predictor, with random idling and back-pressure.
// ---------------------------------------------------------------------------
module triangle_area_heron_tb;

  typedef enum logic [0:0] {
    REQ_SIDES    = 1'b0,
    REQ_VERTICES = 1'b1
  } req_kind_e;

  typedef struct {
    req_kind_e   kind;
    logic [23:0] side [3];
    logic [15:0] vx [3];
    logic [15:0] vy [3];
  } tri_req_t;

  typedef struct {
    logic        exists;
    logic [39:0] area;
  } tri_res_t;

  localparam int LATENCY = 88;
  localparam int STALL_LIMIT = 3000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  tri_res_t area_queue [$];
  int       n_errors;
  int       n_sent;
  int       n_checked;
  int       n_valid_tri;
  int       n_vertex;
  bit       no_idle;
  bit       long_hold;
  int       quiet_cycles;

  triangle_area_heron u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ((128'(t) * 128'(t)) <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned side_length(logic [23:0] code);
    longint unsigned m;
    m = 64'(code);
    if (code[23]) m = (64'd1 << 24) - m;
    return m;
  endfunction

  function automatic longint unsigned vertex_distance(logic [15:0] x1, logic [15:0] y1,
                                                      logic [15:0] x2, logic [15:0] y2);
    longint dx;
    longint dy;
    longint unsigned d2;
    dx = longint'($signed(x1)) - longint'($signed(x2));
    dy = longint'($signed(y1)) - longint'($signed(y2));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    d2 = longint'(dx * dx + dy * dy);
    return isqrt(128'(d2) << (2 * tah_pkg::FRAC_BITS));
  endfunction

  function automatic tri_res_t heron_area(tri_req_t req);
    tri_res_t res;
    longint unsigned a, b, c;
    logic [127:0] prod;
    logic [63:0] q;
    if (req.kind == REQ_SIDES) begin
      a = side_length(req.side[0]);
      b = side_length(req.side[1]);
      c = side_length(req.side[2]);
    end else begin
      c = vertex_distance(req.vx[0], req.vy[0], req.vx[1], req.vy[1]);
      a = vertex_distance(req.vx[1], req.vy[1], req.vx[2], req.vy[2]);
      b = vertex_distance(req.vx[0], req.vy[0], req.vx[2], req.vy[2]);
    end
    res.exists = 1'b0;
    res.area = '0;
    if (a + b >= c && b + c >= a && a + c >= b) begin
      prod = 128'(a + b + c) * 128'(b + c - a);
      prod = prod * 128'(a + c - b) * 128'(a + b - c);
      q = isqrt(prod) >> (tah_pkg::FRAC_BITS + 2);
      res.exists = 1'b1;
      res.area = (q > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : q[39:0];
    end
    return res;
  endfunction

  task automatic send_item(tri_req_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.kind;
    s_axis_tdata  <= {req.vy[2], req.vx[2], req.vy[1], req.vx[1], req.vy[0], req.vx[0],
                      req.side[2], req.side[1], req.side[0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    area_queue.push_back(heron_area(req));
    n_sent++;
    if (req.kind == REQ_VERTICES) n_vertex++;
  endtask

  task automatic finish_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic tri_req_t sides_req(int a, int b, int c);
    tri_req_t r;
    r.kind = REQ_SIDES;
    r.side[0] = a[23:0];
    r.side[1] = b[23:0];
    r.side[2] = c[23:0];
    for (int i = 0; i < 3; i++) begin
      r.vx[i] = $urandom;
      r.vy[i] = $urandom;
    end
    return r;
  endfunction

  function automatic tri_req_t vert_req(int ax, int ay, int bx, int by, int cx, int cy);
    tri_req_t r;
    r.kind = REQ_VERTICES;
    r.vx[0] = ax[15:0];
    r.vy[0] = ay[15:0];
    r.vx[1] = bx[15:0];
    r.vy[1] = by[15:0];
    r.vx[2] = cx[15:0];
    r.vy[2] = cy[15:0];
    for (int i = 0; i < 3; i++) r.side[i] = $urandom;
    return r;
  endfunction

  task automatic test_directed_sides();
    send_item(sides_req(0, 0, 0));
    send_item(sides_req(256, 256, 256));
    send_item(sides_req(256, 256, 512));
    send_item(sides_req(256, 256, 768));
    send_item(sides_req(768, 1024, 1280));
    send_item(sides_req(-768, 1024, -1280));
    send_item(sides_req(-8388608, -8388608, -8388608));
    send_item(sides_req(8388607, 8388607, 8388607));
    send_item(sides_req(8388607, -8388608, 1));
    send_item(sides_req(1, 1, 1));
    send_item(sides_req(-1, 8388607, 8388607));
  endtask

  task automatic test_directed_vertices();
    send_item(vert_req(0, 0, 0, 0, 0, 0));
    send_item(vert_req(0, 0, 3, 0, 0, 4));
    send_item(vert_req(-32768, -32768, 32767, 32767, -32768, 32767));
    send_item(vert_req(-32768, -32768, 32767, 32767, 32767, -32768));
    send_item(vert_req(0, 0, 1, 1, 2, 2));
    send_item(vert_req(-32768, 0, 32767, 0, 0, 0));
    send_item(vert_req(5, 5, 5, 5, 9, -2));
    send_item(vert_req(32767, 32767, 32767, 32767, 32767, 32767));
    send_item(vert_req(-1, -1, 1, 1, -1, 1));
  endtask

  function automatic tri_req_t random_req();
    tri_req_t r;
    int a, b, c, lo, sel, span;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      r = sides_req($urandom, $urandom, $urandom);
    end else if (sel < 5) begin
      span = (sel == 2) ? 1000 : 8388607;
      a = $urandom_range(0, span);
      b = $urandom_range(0, span);
      lo = (a > b) ? a - b : b - a;
      c = $urandom_range(lo, (a + b > 8388608) ? 8388608 : a + b);
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      if ($urandom_range(0, 1)) c = -c;
      r = sides_req(a, b, c);
    end else if (sel < 8) begin
      r = vert_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      span = $urandom_range(1, 64);
      r = vert_req($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
    end
    return r;
  endfunction

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_item(random_req());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 150; i++) send_item(random_req());
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    finish_sending();
    while (area_queue.size() != 0) @(posedge clk_i);
    test_random(20);
  endtask

  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      hold = no_idle ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid && !long_hold) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    tri_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (area_queue.size() == 0) begin
        $display("%0t: result with none expected: exists=%0d area=%0h", $time,
                 m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        want = area_queue.pop_front();
        n_checked++;
        if (want.exists) n_valid_tri++;
        if (m_axis_tuser[0] !== want.exists) begin
          $display("%0t: exists expected %0d actual %0d", $time, want.exists, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata !== want.area) begin
          $display("%0t: area expected %0h actual %0h", $time, want.area, m_axis_tdata);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int waited;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_valid_tri = 0;
    n_vertex = 0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_sides();
    test_directed_vertices();
    test_random(300);
    test_backpressure();
    test_drain_pause();
    test_random(280);
    finish_sending();
    waited = 0;
    while (area_queue.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Sent %0d triangles (%0d by vertices), checked %0d results, %0d valid.",
             n_sent, n_vertex, n_checked, n_valid_tri);
    if (n_errors == 0 && area_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, area_queue.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
